@@ src/procedural_test_texture_pixel_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the procedural test texture pixel core
// Clocked checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PROCEDURAL_TEST_TEXTURE_PIXEL_CORE_MACROS_SVH
`define PROCEDURAL_TEST_TEXTURE_PIXEL_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every edge out of reset
`define PTT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante at one edge implies cons at the same edge
`define PTT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante at one edge implies cons a fixed number of edges later
`define PTT_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`else

`define PTT_ASSERT_ALWAYS(lbl, cond, msg)
`define PTT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PTT_ASSERT_DELAY(lbl, ante, dly, cons, msg)

`endif

`endif

@@ src/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, constants and the palette of the test texture pixel core.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int COORD_W = 7;
  localparam int SPACE_W = 8;
  localparam int CHAN_W  = 8;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_GRID   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARKER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRICK  = 2'd2;

  localparam logic [SPACE_W-1:0] SPACING_RST = 8'd16;

  // register indexes on the APB port
  localparam logic REG_KIND    = 1'b0;
  localparam logic REG_SPACING = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } ptt_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } ptt_out_t;

  // data handed from cell to cell: one restoring-division step per cell on
  // both coordinates by the spacing
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SPACE_W-1:0] div;
    ptt_in_t            coord;
    logic [SPACE_W-1:0] xrem;
    logic [SPACE_W-1:0] yrem;
    logic [COORD_W-1:0] xquo;
    logic [COORD_W-1:0] yquo;
  } ptt_cell_t;

  function automatic ptt_out_t palette(input logic [3:0] idx);
    ptt_out_t c;
    c.alpha = 8'd255;
    unique case (idx)
      4'd0:  {c.red, c.green, c.blue} = {8'd0,   8'd0,   8'd0};
      4'd1:  {c.red, c.green, c.blue} = {8'd32,  8'd32,  8'd36};
      4'd2:  {c.red, c.green, c.blue} = {8'd72,  8'd72,  8'd80};
      4'd3:  {c.red, c.green, c.blue} = {8'd112, 8'd112, 8'd124};
      4'd4:  {c.red, c.green, c.blue} = {8'd176, 8'd176, 8'd188};
      4'd5:  {c.red, c.green, c.blue} = {8'd224, 8'd224, 8'd232};
      4'd6:  {c.red, c.green, c.blue} = {8'd32,  8'd64,  8'd128};
      4'd7:  {c.red, c.green, c.blue} = {8'd48,  8'd96,  8'd192};
      4'd8:  {c.red, c.green, c.blue} = {8'd96,  8'd144, 8'd224};
      4'd9:  {c.red, c.green, c.blue} = {8'd160, 8'd192, 8'd240};
      4'd10: {c.red, c.green, c.blue} = {8'd96,  8'd64,  8'd32};
      4'd11: {c.red, c.green, c.blue} = {8'd144, 8'd96,  8'd48};
      4'd12: {c.red, c.green, c.blue} = {8'd192, 8'd144, 8'd72};
      4'd13: {c.red, c.green, c.blue} = {8'd224, 8'd192, 8'd112};
      4'd14: {c.red, c.green, c.blue} = {8'd128, 8'd48,  8'd48};
      default: {c.red, c.green, c.blue} = {8'd208, 8'd80,  8'd72};
    endcase
    return c;
  endfunction

endpackage

@@ src/ptt_cell.sv @@
// ----------------------------------------------------------------------------
// ptt_cell
// One division cell: brings down one coordinate bit and derives one quotient
// bit of x / spacing and y / spacing, then registers the beat.
// ----------------------------------------------------------------------------
`include "procedural_test_texture_pixel_core_macros.svh"

module ptt_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  ptt_pkg::ptt_cell_t  data_in,
  output logic                valid_out,
  output ptt_pkg::ptt_cell_t  data_out
);
  import ptt_pkg::*;

  localparam int BIT = COORD_W - 1 - STEP;

  logic [SPACE_W:0] xshift;
  logic [SPACE_W:0] yshift;
  logic [SPACE_W:0] div_ext;
  logic             xge;
  logic             yge;
  ptt_cell_t        data_next;

  always_comb begin
    div_ext = {1'b0, data_in.div};
    xshift  = {data_in.xrem, data_in.coord.x_coord[BIT]};
    yshift  = {data_in.yrem, data_in.coord.y_coord[BIT]};
    xge     = xshift >= div_ext;
    yge     = yshift >= div_ext;

    data_next      = data_in;
    // partial remainder stays below the divisor, so it fits SPACE_W bits
    data_next.xrem = xge ? SPACE_W'(xshift - div_ext) : xshift[SPACE_W-1:0];
    data_next.yrem = yge ? SPACE_W'(yshift - div_ext) : yshift[SPACE_W-1:0];
    data_next.xquo = {data_in.xquo[COORD_W-2:0], xge};
    data_next.yquo = {data_in.yquo[COORD_W-2:0], yge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

  `PTT_ASSERT_IMPLY(a_xrem_below_div, valid_out, data_out.xrem < data_out.div, "x remainder not below spacing")
  `PTT_ASSERT_IMPLY(a_yrem_below_div, valid_out, data_out.yrem < data_out.div, "y remainder not below spacing")
  `PTT_ASSERT_IMPLY(a_div_nonzero, valid_out, data_out.div != '0, "zero divisor in cell chain")

endmodule

@@ src/ptt_shade.sv @@
// ----------------------------------------------------------------------------
// ptt_shade
// Output cell: picks the palette index for the selected pattern from the
// finished quotients and remainders, looks up the colour and registers it.
// ----------------------------------------------------------------------------
module ptt_shade (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  ptt_pkg::ptt_cell_t  data_in,
  output logic                done,
  output ptt_pkg::ptt_out_t   color
);
  import ptt_pkg::*;

  localparam logic [3:0] IDX_BLACK      = 4'd0;
  localparam logic [3:0] IDX_DARK       = 4'd1;
  localparam logic [3:0] IDX_GREY       = 4'd2;
  localparam logic [3:0] IDX_MARK_LINE  = 4'd6;
  localparam logic [3:0] IDX_MINOR      = 4'd7;
  localparam logic [3:0] IDX_MAJOR      = 4'd9;
  localparam logic [3:0] IDX_MORTAR     = 4'd10;
  localparam logic [3:0] IDX_BRICK_LO   = 4'd11;
  localparam logic [3:0] IDX_BRICK_HI   = 4'd12;
  localparam logic [3:0] IDX_MARK_FILL  = 4'd14;
  localparam logic [3:0] IDX_MARK_EDGE  = 4'd15;

  localparam logic [COORD_W-1:0] MID    = 7'd64;
  localparam logic [COORD_W-1:0] HALF_W = 7'd16;
  localparam logic [COORD_W-1:0] HALF_H = 7'd36;

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic               xzero;
  logic               yzero;
  logic               major;
  logic [3:0]         grid_idx;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               in_rect;
  logic [3:0]         marker_idx;
  logic [3:0]         brick_idx;
  logic [3:0]         idx;

  always_comb begin
    x = data_in.coord.x_coord;
    y = data_in.coord.y_coord;

    // grid: a multiple of 4*spacing is a multiple of spacing with quotient % 4 == 0
    xzero = data_in.xrem == '0;
    yzero = data_in.yrem == '0;
    major = (xzero && data_in.xquo[1:0] == 2'd0) || (yzero && data_in.yquo[1:0] == 2'd0);
    if (major) begin
      grid_idx = IDX_MAJOR;
    end else if (xzero || yzero) begin
      grid_idx = IDX_MINOR;
    end else begin
      grid_idx = (data_in.xquo[0] ^ data_in.yquo[0]) ? IDX_GREY : IDX_DARK;
    end

    // player marker
    dx      = (x >= MID) ? x - MID : MID - x;
    dy      = (y >= MID) ? y - MID : MID - y;
    in_rect = (dx <= HALF_W) && (dy <= HALF_H);
    if (in_rect && (dx == HALF_W || dy == HALF_H)) begin
      marker_idx = IDX_MARK_EDGE;
    end else if (in_rect) begin
      marker_idx = IDX_MARK_FILL;
    end else begin
      marker_idx = (x[3:0] == 4'd0 || y[3:0] == 4'd0) ? IDX_MARK_LINE : IDX_DARK;
    end

    // brick wall: odd rows shift by half a brick (16 of 32)
    if ((x[4] == y[4] && x[3:0] == 4'd0) || y[3:0] == 4'd0) begin
      brick_idx = IDX_MORTAR;
    end else begin
      brick_idx = (x[3] ^ y[3]) ? IDX_BRICK_HI : IDX_BRICK_LO;
    end

    unique case (data_in.kind)
      KIND_GRID:   idx = grid_idx;
      KIND_MARKER: idx = marker_idx;
      KIND_BRICK:  idx = brick_idx;
      default:     idx = IDX_BLACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    color <= palette(idx);
  end

endmodule

@@ src/procedural_test_texture_pixel_core.sv @@
// ----------------------------------------------------------------------------
// procedural_test_texture_pixel_core
// Test-pattern pixel generator: grid, player marker or brick wall colour for
// one pixel coordinate, from a 16-entry RGBA palette.
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// coord     start, busy, coord             beat taken when start && !busy
// color     done, color                    one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr,  APB, pready always high
//           pwdata, prdata, pready
//
// One beat per clock; busy is never raised. The path is a chain of seven
// division cells (one quotient bit of x and y / spacing per cell) followed by
// the registered pattern and palette cell.
// rst is synchronous; it clears the valid bits of the chain and sets the config registers to grid and spacing 16.
// ----------------------------------------------------------------------------
`include "procedural_test_texture_pixel_core_macros.svh"

module procedural_test_texture_pixel_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ptt_pkg::ptt_in_t   coord,
  output logic               done,
  output ptt_pkg::ptt_out_t  color,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ptt_pkg::*;

  localparam int LATENCY = COORD_W + 1;

  logic [KIND_W-1:0]  kind;
  logic [SPACE_W-1:0] spacing;
  logic               reg_sel;
  logic               wr_en;

  logic      cell_valid [0:COORD_W];
  ptt_cell_t cell_data  [0:COORD_W];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= KIND_GRID;
      spacing <= SPACING_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KIND:    kind    <= pwdata[KIND_W-1:0];
        REG_SPACING: spacing <= pwdata[SPACE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KIND:    prdata = {{(32-KIND_W){1'b0}}, kind};
      REG_SPACING: prdata = {{(32-SPACE_W){1'b0}}, spacing};
      default:     prdata = '0;
    endcase
  end

  // head of the chain: zero partial remainders, spacing 0 runs as 1
  always_comb begin
    cell_valid[0]      = start && !busy;
    cell_data[0].kind  = kind;
    cell_data[0].div   = (spacing == '0) ? SPACE_W'(1) : spacing;
    cell_data[0].coord = coord;
    cell_data[0].xrem  = '0;
    cell_data[0].yrem  = '0;
    cell_data[0].xquo  = '0;
    cell_data[0].yquo  = '0;
  end

  for (genvar g = 0; g < COORD_W; g++) begin : g_cell
    ptt_cell #(
      .STEP (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (cell_valid[g]),
      .data_in   (cell_data[g]),
      .valid_out (cell_valid[g+1]),
      .data_out  (cell_data[g+1])
    );
  end

  ptt_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .valid_in (cell_valid[COORD_W]),
    .data_in  (cell_data[COORD_W]),
    .done     (done),
    .color    (color)
  );

  `PTT_ASSERT_DELAY(a_beat_latency, start && !busy, LATENCY, done, "accepted beat did not come out")
  `PTT_ASSERT_DELAY(a_no_spurious, !start, LATENCY, !done, "result without an accepted beat")
  `PTT_ASSERT_IMPLY(a_alpha_opaque, done, color.alpha == 8'd255, "alpha not opaque")
  `PTT_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

@@ sim/ptt_color_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptt_color_checker
// Watches the coord, color and APB channels of the test texture pixel core.
// Tracks the pattern registers, predicts the RGBA color of every accepted
// coordinate beat and compares each color strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module ptt_color_checker
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  ptt_in_t     coord,
  input  logic        done,
  input  ptt_out_t    color,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);

  logic [KIND_W-1:0]  pattern_sel;
  logic [SPACE_W-1:0] minor_spacing;
  ptt_out_t           pending_colors[$];

  function automatic logic [23:0] shade_rgb(input int idx);
    case (idx)
      0:       return {8'd0,   8'd0,   8'd0};
      1:       return {8'd32,  8'd32,  8'd36};
      2:       return {8'd72,  8'd72,  8'd80};
      3:       return {8'd112, 8'd112, 8'd124};
      4:       return {8'd176, 8'd176, 8'd188};
      5:       return {8'd224, 8'd224, 8'd232};
      6:       return {8'd32,  8'd64,  8'd128};
      7:       return {8'd48,  8'd96,  8'd192};
      8:       return {8'd96,  8'd144, 8'd224};
      9:       return {8'd160, 8'd192, 8'd240};
      10:      return {8'd96,  8'd64,  8'd32};
      11:      return {8'd144, 8'd96,  8'd48};
      12:      return {8'd192, 8'd144, 8'd72};
      13:      return {8'd224, 8'd192, 8'd112};
      14:      return {8'd128, 8'd48,  8'd48};
      default: return {8'd208, 8'd80,  8'd72};
    endcase
  endfunction

  function automatic ptt_out_t pixel_color(input logic [KIND_W-1:0] sel,
                                           input logic [SPACE_W-1:0] spacing,
                                           input ptt_in_t pix);
    int x, y, s, dx, dy, shift, idx;
    bit in_box;
    ptt_out_t c;
    x = pix.x_coord;
    y = pix.y_coord;
    if (sel == KIND_GRID) begin
      s = (spacing == 0) ? 1 : spacing;
      if (x % (4 * s) == 0 || y % (4 * s) == 0) idx = 9;
      else if (x % s == 0 || y % s == 0) idx = 7;
      else idx = (((x / s) + (y / s)) % 2 != 0) ? 2 : 1;
    end else if (sel == KIND_MARKER) begin
      dx = (x > 64) ? x - 64 : 64 - x;
      dy = (y > 64) ? y - 64 : 64 - y;
      in_box = dx <= 16 && dy <= 36;
      if (in_box && (dx == 16 || dy == 36)) idx = 15;
      else if (in_box) idx = 14;
      else idx = (x % 16 == 0 || y % 16 == 0) ? 6 : 1;
    end else if (sel == KIND_BRICK) begin
      // odd brick rows are offset by half a brick
      shift = ((y / 16) % 2 != 0) ? 16 : 0;
      if ((x + shift) % 32 == 0 || y % 16 == 0) idx = 10;
      else idx = (((x / 8) + (y / 8)) % 2 != 0) ? 12 : 11;
    end else begin
      idx = 0;
    end
    {c.red, c.green, c.blue} = shade_rgb(idx);
    c.alpha = 8'd255;
    return c;
  endfunction

  task automatic check_chan(input string name, input logic [7:0] exp_v,
                            input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ptt_out_t want;
    logic [31:0] reg_val;
    if (rst) begin
      pattern_sel   = KIND_GRID;
      minor_spacing = SPACING_RST;
      pending_colors.delete();
    end else begin
      if (done) begin
        if (pending_colors.size() == 0) begin
          $error("color beat with no pixel outstanding");
          errors++;
        end else begin
          want = pending_colors.pop_front();
          check_chan("red",   want.red,   color.red);
          check_chan("green", want.green, color.green);
          check_chan("blue",  want.blue,  color.blue);
          check_chan("alpha", want.alpha, color.alpha);
        end
      end
      if (start && !busy)
        pending_colors = {pending_colors, pixel_color(pattern_sel, minor_spacing, coord)};
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_SPACING) minor_spacing = pwdata[SPACE_W-1:0];
          else pattern_sel = pwdata[KIND_W-1:0];
        end else begin
          reg_val = (paddr[2] == REG_SPACING) ? 32'(minor_spacing) : 32'(pattern_sel);
          if (prdata[SPACE_W-1:0] !== reg_val[SPACE_W-1:0]) begin
            $error("prdata mismatch: expected %0d, got %0d", reg_val, prdata);
            errors++;
          end
        end
      end
    end
    outstanding = pending_colors.size();
  end

endmodule

@@ sim/tb_procedural_test_texture_pixel_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_procedural_test_texture_pixel_core
// Drives coordinate beats and APB register writes into the pixel core across
// grid, marker, brick and unused pattern settings, with random idle gaps.
// The color checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_procedural_test_texture_pixel_core;
  import ptt_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PIPE_LAT     = 8;
  localparam int          PHASE_PIXELS = 72;
  localparam logic [2:0]  ADDR_KIND    = {REG_KIND, 2'b00};
  localparam logic [2:0]  ADDR_SPACING = {REG_SPACING, 2'b00};
  // pattern select with no pattern behind it
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  ptt_in_t     coord;
  logic        done;
  ptt_out_t    color;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          outstanding;
  int          cycles;

  procedural_test_texture_pixel_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .coord   (coord),
    .done    (done),
    .color   (color),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ptt_color_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .coord       (coord),
    .done        (done),
    .color       (color),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // mostly uniform, the rest on pattern edges and texture borders
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(9);
    if (r < 7) return COORD_W'($urandom_range(127));
    case ($urandom_range(5))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return COORD_W'(16 * $urandom_range(7));
      3:       return COORD_W'(16 * $urandom_range(7, 1) - 1);
      4:       return COORD_W'(16 * $urandom_range(7) + 1);
      default: begin
        case ($urandom_range(3))
          0:       return 7'd28;
          1:       return 7'd100;
          2:       return 7'd48;
          default: return 7'd80;
        endcase
      end
    endcase
  endfunction

  // setup then access; the bus is left selected so transfers can chain
  task automatic bus_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_pattern(input logic [KIND_W-1:0] kind,
                             input logic [SPACE_W-1:0] spacing);
    bus_access(1'b1, ADDR_KIND, 32'(kind));
    bus_access(1'b1, ADDR_SPACING, 32'(spacing));
    bus_access(1'b0, ADDR_KIND, 32'd0);
    bus_access(1'b0, ADDR_SPACING, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input bit steady);
    int gap;
    start         <= 1'b1;
    coord.x_coord <= x;
    coord.y_coord <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every color beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [KIND_W-1:0]  kinds[12];
    logic [SPACE_W-1:0] spacings[12];
    bit steady;
    kinds    = '{KIND_GRID, KIND_GRID, KIND_GRID, KIND_GRID, KIND_GRID, KIND_GRID,
                 KIND_MARKER, KIND_BRICK, KIND_NONE, KIND_GRID, KIND_MARKER, KIND_BRICK};
    spacings = '{8'd16, 8'd0, 8'd1, 8'd3, 8'd128, 8'd255,
                 8'd16, 8'd16, 8'd16, 8'd0, 8'd0, 8'd0};
    spacings[9]  = SPACE_W'($urandom_range(255));
    spacings[10] = SPACE_W'($urandom_range(255));
    spacings[11] = SPACE_W'($urandom_range(255));

    rst     <= 1'b1;
    start   <= 1'b0;
    coord   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings first, then edges of every pattern
    send_pixel(7'd0, 7'd0, 1'b0);
    send_pixel(7'd127, 7'd127, 1'b0);
    send_pixel(7'd16, 7'd5, 1'b0);
    send_pixel(7'd17, 7'd18, 1'b1);
    send_pixel(7'd64, 7'd3, 1'b0);
    wait_drained();
    set_pattern(KIND_GRID, 8'd0);
    send_pixel(7'd5, 7'd9, 1'b0);
    send_pixel(7'd0, 7'd3, 1'b0);
    wait_drained();
    set_pattern(KIND_GRID, 8'd255);
    send_pixel(7'd0, 7'd50, 1'b0);
    send_pixel(7'd127, 7'd127, 1'b0);
    wait_drained();
    set_pattern(KIND_MARKER, 8'd255);
    send_pixel(7'd64, 7'd64, 1'b1);
    send_pixel(7'd48, 7'd64, 1'b1);
    send_pixel(7'd80, 7'd28, 1'b0);
    send_pixel(7'd81, 7'd100, 1'b0);
    send_pixel(7'd47, 7'd30, 1'b0);
    send_pixel(7'd16, 7'd5, 1'b0);
    wait_drained();
    set_pattern(KIND_BRICK, 8'd0);
    send_pixel(7'd0, 7'd0, 1'b0);
    send_pixel(7'd16, 7'd16, 1'b0);
    send_pixel(7'd32, 7'd5, 1'b1);
    send_pixel(7'd15, 7'd17, 1'b0);
    send_pixel(7'd8, 7'd9, 1'b0);
    wait_drained();
    set_pattern(KIND_NONE, 8'd16);
    send_pixel(7'd77, 7'd33, 1'b0);
    wait_drained();

    // random phases, one register setting each
    for (int p = 0; p < 12; p++) begin
      set_pattern(kinds[p], spacings[p]);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        steady = (p % 4 == 1) || (n >= 20 && n < 35);
        send_pixel(pick_coord(), pick_coord(), steady);
        if ($urandom_range(99) < 2) wait_drained();
      end
      wait_drained();
    end

    repeat (PIPE_LAT + 4) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
